FILE: rtl/rhg_pkg.sv
`default_nettype none

package rhg_pkg;

    // Pixel channel and result field width
    localparam int CHAN_W = 8;

    // Configuration port geometry
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register indexes (taken from paddr[2])
    localparam logic REG_SAT_THRESHOLD = 1'b0;

    // Arithmetic constants
    localparam logic [CHAN_W-1:0] FULL_SCALE        = 8'd255;
    localparam logic [CHAN_W-1:0] SAT_THRESHOLD_RST = 8'd50;

    // Hue numerator (< 6 * 255), hue dividend (num * 255), saturation dividend
    localparam int HNUM_W = 11;
    localparam int HDIV_W = 19;
    localparam int SDIV_W = 16;
    localparam int QUO_W  = 8;

    // Dominant channel
    typedef enum logic [1:0] {
        DOM_RED   = 2'd0,
        DOM_GREEN = 2'd1,
        DOM_BLUE  = 2'd2
    } t_dom;

endpackage

`default_nettype wire

FILE: rtl/rhg_pix_if.sv
`default_nettype none

interface rhg_pix_if;

    logic                      valid;
    logic                      ready;
    logic [rhg_pkg::CHAN_W-1:0] red;
    logic [rhg_pkg::CHAN_W-1:0] green;
    logic [rhg_pkg::CHAN_W-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);

endinterface

`default_nettype wire

FILE: rtl/rhg_hsl_if.sv
`default_nettype none

interface rhg_hsl_if;

    logic                      valid;
    logic                      ready;
    logic [rhg_pkg::CHAN_W-1:0] gray;
    logic [rhg_pkg::CHAN_W-1:0] hue;
    logic [rhg_pkg::CHAN_W-1:0] saturation;
    logic [rhg_pkg::CHAN_W-1:0] lightness;

    modport source (output valid, output gray, output hue, output saturation,
                    output lightness, input ready);
    modport sink   (input valid, input gray, input hue, input saturation,
                    input lightness, output ready);

endinterface

`default_nettype wire

FILE: rtl/rgb_hsl_hue_gray_map_top.sv
`default_nettype none

// RGB to HSL converter with a hue-derived gray level.
// i_pix carries one 8-bit RGB pixel per transaction (valid/ready); o_hsl
// returns gray, hue, saturation and lightness for it, in order, one result
// transaction per pixel. The APB port holds one register, sat_threshold at
// byte address 0; writes take effect at the access cycle, reads return it.
// From input transaction to valid result the pipeline runs thus: two stages
// find max/min and the hue numerator, one forms the dividends, eight stages
// of a restoring divider resolve one quotient bit each for hue and
// saturation in parallel, and a last register applies the gray threshold.
// Throughput is one pixel per cycle. The whole pipeline advances on one
// enable: while the output register holds a result the receiver has not
// taken, every stage holds and i_pix.ready stays low; bubbles are filled
// whenever the output slot frees. Synchronous active-low reset clears all
// valid bits and sets sat_threshold to 50.
module rgb_hsl_hue_gray_map_top (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    rhg_pix_if.sink                           i_pix,
    rhg_hsl_if.source                         o_hsl,
    input  wire                               psel,
    input  wire                               penable,
    input  wire                               pwrite,
    input  wire  [rhg_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire  [rhg_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [rhg_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);

    localparam int CW   = rhg_pkg::CHAN_W;
    localparam int QW   = rhg_pkg::QUO_W;
    localparam int HW   = rhg_pkg::HDIV_W;
    localparam int SW   = rhg_pkg::SDIV_W;
    localparam int NW   = rhg_pkg::HNUM_W;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [CW-1:0] r_sat_thr;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat_thr <= rhg_pkg::SAT_THRESHOLD_RST;
        end else if (psel && penable && pwrite && pready
                     && (paddr[2] == rhg_pkg::REG_SAT_THRESHOLD)) begin
            r_sat_thr <= pwdata[CW-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == rhg_pkg::REG_SAT_THRESHOLD) begin
            prdata[CW-1:0] = r_sat_thr;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline enable: advance when the output slot is free or drains
    // ------------------------------------------------------------------
    logic r_out_vld;
    logic en;

    assign en          = !r_out_vld || o_hsl.ready;
    assign i_pix.ready = en;

    // ------------------------------------------------------------------
    // Stage 1: max, min and dominant channel
    // ------------------------------------------------------------------
    logic           r_s1_vld;
    logic [CW-1:0]  r_s1_hi, r_s1_lo, r_s1_r, r_s1_g, r_s1_b;
    rhg_pkg::t_dom  r_s1_dom;
    logic [CW-1:0]  n_s1_hi, n_s1_lo;
    rhg_pkg::t_dom  n_s1_dom;

    always_comb begin
        n_s1_hi  = i_pix.red;
        n_s1_lo  = i_pix.red;
        n_s1_dom = rhg_pkg::DOM_RED;
        if (i_pix.green > n_s1_hi) begin
            n_s1_hi  = i_pix.green;
            n_s1_dom = rhg_pkg::DOM_GREEN;
        end
        if (i_pix.blue > n_s1_hi) begin
            n_s1_hi  = i_pix.blue;
            n_s1_dom = rhg_pkg::DOM_BLUE;
        end
        if (i_pix.green < n_s1_lo) n_s1_lo = i_pix.green;
        if (i_pix.blue < n_s1_lo)  n_s1_lo = i_pix.blue;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (en) begin
            r_s1_vld <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_hi  <= n_s1_hi;
            r_s1_lo  <= n_s1_lo;
            r_s1_dom <= n_s1_dom;
            r_s1_r   <= i_pix.red;
            r_s1_g   <= i_pix.green;
            r_s1_b   <= i_pix.blue;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: delta, hue numerator, saturation denominator, lightness
    // ------------------------------------------------------------------
    logic           r_s2_vld;
    logic [CW-1:0]  r_s2_delta, r_s2_den, r_s2_light;
    logic [NW-1:0]  r_s2_num;
    logic [CW-1:0]  n_s2_delta;
    logic [CW:0]    n_s2_sum;
    logic [CW-1:0]  n_s2_den;
    logic [NW-1:0]  n_s2_num;
    logic [NW-1:0]  n_s2_d6;

    always_comb begin
        n_s2_delta = r_s1_hi - r_s1_lo;
        n_s2_sum   = {1'b0, r_s1_hi} + {1'b0, r_s1_lo};
        n_s2_d6    = {1'b0, n_s2_delta, 2'b00} + {2'b00, n_s2_delta, 1'b0};
        // 255 - |sum - 255|
        if (n_s2_sum >= {1'b0, rhg_pkg::FULL_SCALE}) begin
            n_s2_den = CW'(10'd510 - {1'b0, n_s2_sum});
        end else begin
            n_s2_den = n_s2_sum[CW-1:0];
        end
        // hexagon position times delta, kept non-negative
        case (r_s1_dom)
            rhg_pkg::DOM_RED: begin
                if (r_s1_g >= r_s1_b) begin
                    n_s2_num = {3'b000, r_s1_g - r_s1_b};
                end else begin
                    n_s2_num = n_s2_d6 - {3'b000, r_s1_b - r_s1_g};
                end
            end
            rhg_pkg::DOM_GREEN: begin
                n_s2_num = ({2'b00, n_s2_delta, 1'b0} + {3'b000, r_s1_b})
                           - {3'b000, r_s1_r};
            end
            rhg_pkg::DOM_BLUE: begin
                n_s2_num = ({1'b0, n_s2_delta, 2'b00} + {3'b000, r_s1_r})
                           - {3'b000, r_s1_g};
            end
            default: begin
                n_s2_num = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (en) begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_delta <= n_s2_delta;
            r_s2_den   <= n_s2_den;
            r_s2_num   <= n_s2_num;
            r_s2_light <= n_s2_sum[CW:1];
        end
    end

    // ------------------------------------------------------------------
    // Divider pipeline: index 0 holds the dividends, each later index
    // resolves one quotient bit, most significant first
    // ------------------------------------------------------------------
    logic           r_dv_vld   [0:QW];
    logic           r_dv_nz    [0:QW];
    logic [HW-1:0]  r_dv_hrem  [0:QW];
    logic [NW-1:0]  r_dv_hden  [0:QW];
    logic [SW-1:0]  r_dv_srem  [0:QW];
    logic [CW-1:0]  r_dv_sden  [0:QW];
    logic [QW-1:0]  r_dv_hq    [0:QW];
    logic [QW-1:0]  r_dv_sq    [0:QW];
    logic [CW-1:0]  r_dv_light [0:QW];

    // form num*255, 6*delta and delta*255
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_vld[0] <= 1'b0;
        end else if (en) begin
            r_dv_vld[0] <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv_nz[0]    <= (r_s2_delta != '0);
            r_dv_hrem[0]  <= {r_s2_num, 8'b0} - {8'b0, r_s2_num};
            r_dv_hden[0]  <= {1'b0, r_s2_delta, 2'b00} + {2'b00, r_s2_delta, 1'b0};
            r_dv_srem[0]  <= {r_s2_delta, 8'b0} - {8'b0, r_s2_delta};
            r_dv_sden[0]  <= r_s2_den;
            r_dv_hq[0]    <= '0;
            r_dv_sq[0]    <= '0;
            r_dv_light[0] <= r_s2_light;
        end
    end

    for (genvar j = 0; j < QW; j++) begin : g_div
        localparam int SH = QW - 1 - j;

        logic [HW-1:0] hsub;
        logic [SW-1:0] ssub;
        logic          hbit, sbit;

        // compare and subtract the shifted divisor
        always_comb begin
            hsub = HW'({{(HW-NW){1'b0}}, r_dv_hden[j]} << SH);
            ssub = SW'({{(SW-CW){1'b0}}, r_dv_sden[j]} << SH);
            hbit = (r_dv_hrem[j] >= hsub);
            sbit = (r_dv_srem[j] >= ssub);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[j+1] <= 1'b0;
            end else if (en) begin
                r_dv_vld[j+1] <= r_dv_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv_nz[j+1]    <= r_dv_nz[j];
                r_dv_hrem[j+1]  <= hbit ? (r_dv_hrem[j] - hsub) : r_dv_hrem[j];
                r_dv_srem[j+1]  <= sbit ? (r_dv_srem[j] - ssub) : r_dv_srem[j];
                r_dv_hden[j+1]  <= r_dv_hden[j];
                r_dv_sden[j+1]  <= r_dv_sden[j];
                r_dv_hq[j+1]    <= {r_dv_hq[j][QW-2:0], hbit};
                r_dv_sq[j+1]    <= {r_dv_sq[j][QW-2:0], sbit};
                r_dv_light[j+1] <= r_dv_light[j];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register: zero hue and saturation for gray pixels, apply
    // the saturation threshold
    // ------------------------------------------------------------------
    logic [CW-1:0] r_out_gray, r_out_hue, r_out_sat, r_out_light;
    logic [CW-1:0] n_out_hue, n_out_sat, n_out_gray;

    always_comb begin
        n_out_hue  = r_dv_nz[QW] ? r_dv_hq[QW] : '0;
        n_out_sat  = r_dv_nz[QW] ? r_dv_sq[QW] : '0;
        n_out_gray = (n_out_sat < r_sat_thr) ? '0 : (rhg_pkg::FULL_SCALE - n_out_hue);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_dv_vld[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_gray  <= n_out_gray;
            r_out_hue   <= n_out_hue;
            r_out_sat   <= n_out_sat;
            r_out_light <= r_dv_light[QW];
        end
    end

    assign o_hsl.valid      = r_out_vld;
    assign o_hsl.gray       = r_out_gray;
    assign o_hsl.hue        = r_out_hue;
    assign o_hsl.saturation = r_out_sat;
    assign o_hsl.lightness  = r_out_light;

endmodule

`default_nettype wire
